FILE: hdl/obbq_pkg.sv
// obbq_pkg: widths, register codes and word types for the oriented box point query
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package obbq_pkg;

	// number format
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int AXIS_W    = 18;
	localparam int EXT_W     = 31;

	// derived datapath widths
	localparam int DIFF_W  = COORD_W + 1;          // point minus center
	localparam int PROD_W  = DIFF_W + AXIS_W;      // difference times axis
	localparam int SUM_W   = PROD_W + 1;           // dot product
	localparam int LOC_W   = SUM_W - FRAC_BITS;    // local coordinate after rescale
	localparam int K_W     = EXT_W + 1;            // clamped local coordinate
	localparam int KPROD_W = K_W + AXIS_W;
	localparam int KSUM_W  = KPROD_W + 1;
	localparam int OFS_W   = KSUM_W - FRAC_BITS;   // world offset from center
	localparam int WSUM_W  = OFS_W + 1;            // center plus offset
	localparam int SQ_W    = 2 * COORD_W;
	localparam int R2_W    = 2 * EXT_W;
	localparam int IDX_W   = 3;

	localparam logic [AXIS_W-1:0] AXIS_ONE = AXIS_W'(1 << FRAC_BITS);
	localparam logic [EXT_W-1:0]  EXT_ONE  = EXT_W'(1 << FRAC_BITS);

	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_RIGHT_X     = 3'd2,
		REG_RIGHT_Y     = 3'd3,
		REG_HALF_WIDTH  = 3'd4,
		REG_HALF_HEIGHT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic [EXT_W-1:0]          disc_radius;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] closest_x;
		logic signed [COORD_W-1:0] closest_y;
		logic                      inside_box;
		logic                      disc_overlaps;
	} out_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [AXIS_W-1:0]  right_x;
		logic signed [AXIS_W-1:0]  right_y;
		logic [EXT_W-1:0]          half_width;
		logic [EXT_W-1:0]          half_height;
	} cfg_t;

	// projection stage to reconstruction stage
	typedef struct packed {
		logic                      valid;
		logic signed [K_W-1:0]     kx;
		logic signed [K_W-1:0]     ky;
		logic                      in_box;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic [EXT_W-1:0]          rad;
	} proj_t;

	// reconstruction stage to distance stage
	typedef struct packed {
		logic                      valid;
		logic signed [COORD_W-1:0] wx;
		logic signed [COORD_W-1:0] wy;
		logic                      in_box;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic [EXT_W-1:0]          rad;
	} recon_t;

endpackage

`default_nettype wire

FILE: hdl/obbq_cfg.sv
// obbq_cfg: box setup registers behind the plain write port
// depends on obbq_pkg
`timescale 1ns / 1ps
`default_nettype none

module obbq_cfg import obbq_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [IDX_W-1:0]   wr_index,
	input  wire logic [COORD_W-1:0] wr_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.right_x     <= AXIS_ONE;
			cfg_q.right_y     <= '0;
			cfg_q.half_width  <= EXT_ONE;
			cfg_q.half_height <= EXT_ONE;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CENTER_X:    cfg_q.center_x    <= wr_data[COORD_W-1:0];
				REG_CENTER_Y:    cfg_q.center_y    <= wr_data[COORD_W-1:0];
				REG_RIGHT_X:     cfg_q.right_x     <= wr_data[AXIS_W-1:0];
				REG_RIGHT_Y:     cfg_q.right_y     <= wr_data[AXIS_W-1:0];
				REG_HALF_WIDTH:  cfg_q.half_width  <= wr_data[EXT_W-1:0];
				REG_HALF_HEIGHT: cfg_q.half_height <= wr_data[EXT_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/obbq_proj.sv
// obbq_proj: moves the point into box-local coordinates and clamps to the extents
// depends on obbq_pkg; four register stages
`timescale 1ns / 1ps
`default_nettype none

module obbq_proj import obbq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_word_t in_word,
	input  wire cfg_t     cfg,
	output proj_t         proj
);

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;
	logic signed [COORD_W-1:0] px_s1, py_s1, px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	logic [EXT_W-1:0]          rad_s1, rad_s2, rad_s3, rad_s4;
	logic signed [PROD_W-1:0]  xr_s2, yr_s2, xs_s2, ys_s2;
	logic signed [LOC_W-1:0]   lx_s3, ly_s3;
	logic signed [K_W-1:0]     kx_s4, ky_s4;
	logic                      inside_s4;

	logic signed [SUM_W-1:0]   sum_x, sum_y;
	logic signed [LOC_W-1:0]   hw_e, hh_e;
	logic                      gtx, ltx, gty, lty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// dot products, floor rescale
	always_comb begin
		sum_x = SUM_W'(xr_s2) + SUM_W'(yr_s2);
		sum_y = SUM_W'(ys_s2) - SUM_W'(xs_s2);
	end

	// extents as signed local values
	always_comb begin
		hw_e = $signed({{(LOC_W-EXT_W){1'b0}}, cfg.half_width});
		hh_e = $signed({{(LOC_W-EXT_W){1'b0}}, cfg.half_height});
		gtx  = lx_s3 > hw_e;
		ltx  = lx_s3 < -hw_e;
		gty  = ly_s3 > hh_e;
		lty  = ly_s3 < -hh_e;
	end

	always_ff @(posedge clk) begin
		// s1: offset from center
		dx_s1  <= DIFF_W'(in_word.point_x) - DIFF_W'(cfg.center_x);
		dy_s1  <= DIFF_W'(in_word.point_y) - DIFF_W'(cfg.center_y);
		px_s1  <= in_word.point_x;
		py_s1  <= in_word.point_y;
		rad_s1 <= in_word.disc_radius;
		// s2: axis products
		xr_s2  <= PROD_W'(dx_s1 * $signed(cfg.right_x));
		yr_s2  <= PROD_W'(dy_s1 * $signed(cfg.right_y));
		xs_s2  <= PROD_W'(dx_s1 * $signed(cfg.right_y));
		ys_s2  <= PROD_W'(dy_s1 * $signed(cfg.right_x));
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		rad_s2 <= rad_s1;
		// s3: local coordinates
		lx_s3  <= LOC_W'(sum_x >>> FRAC_BITS);
		ly_s3  <= LOC_W'(sum_y >>> FRAC_BITS);
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		rad_s3 <= rad_s2;
		// s4: clamp and containment
		kx_s4  <= gtx ? K_W'(hw_e) : (ltx ? K_W'(-hw_e) : K_W'(lx_s3));
		ky_s4  <= gty ? K_W'(hh_e) : (lty ? K_W'(-hh_e) : K_W'(ly_s3));
		inside_s4 <= !(gtx || ltx || gty || lty);
		px_s4  <= px_s3;
		py_s4  <= py_s3;
		rad_s4 <= rad_s3;
	end

	always_comb begin
		proj.valid  = v_s4;
		proj.kx     = kx_s4;
		proj.ky     = ky_s4;
		proj.in_box = inside_s4;
		proj.px     = px_s4;
		proj.py     = py_s4;
		proj.rad    = rad_s4;
	end

endmodule

`default_nettype wire

FILE: hdl/obbq_recon.sv
// obbq_recon: maps the clamped local point back to world space with saturation
// depends on obbq_pkg; three register stages
`timescale 1ns / 1ps
`default_nettype none

module obbq_recon import obbq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire proj_t proj,
	input  wire cfg_t  cfg,
	output recon_t     recon
);

	logic                      v_s5, v_s6, v_s7;
	logic signed [KPROD_W-1:0] xr_s5, ys_s5, xs_s5, yr_s5;
	logic signed [OFS_W-1:0]   ox_s6, oy_s6;
	logic signed [COORD_W-1:0] wx_s7, wy_s7;
	logic                      in_s5, in_s6, in_s7;
	logic signed [COORD_W-1:0] px_s5, py_s5, px_s6, py_s6, px_s7, py_s7;
	logic [EXT_W-1:0]          rad_s5, rad_s6, rad_s7;

	logic signed [KSUM_W-1:0]  sum_x, sum_y;
	logic signed [WSUM_W-1:0]  abs_x, abs_y;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WSUM_W-1:0] v);
		logic [WSUM_W-COORD_W:0] top;
		top = v[WSUM_W-1:COORD_W-1];
		if ((&top) || !(|top)) begin
			return v[COORD_W-1:0];
		end
		return v[WSUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s5 <= proj.valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_comb begin
		sum_x = KSUM_W'(xr_s5) - KSUM_W'(ys_s5);
		sum_y = KSUM_W'(xs_s5) + KSUM_W'(yr_s5);
		abs_x = WSUM_W'(cfg.center_x) + WSUM_W'(ox_s6);
		abs_y = WSUM_W'(cfg.center_y) + WSUM_W'(oy_s6);
	end

	always_ff @(posedge clk) begin
		// s5: products with the axes (up = -ry, rx)
		xr_s5  <= KPROD_W'(proj.kx * $signed(cfg.right_x));
		ys_s5  <= KPROD_W'(proj.ky * $signed(cfg.right_y));
		xs_s5  <= KPROD_W'(proj.kx * $signed(cfg.right_y));
		yr_s5  <= KPROD_W'(proj.ky * $signed(cfg.right_x));
		in_s5  <= proj.in_box;
		px_s5  <= proj.px;
		py_s5  <= proj.py;
		rad_s5 <= proj.rad;
		// s6: world offset, floor rescale
		ox_s6  <= OFS_W'(sum_x >>> FRAC_BITS);
		oy_s6  <= OFS_W'(sum_y >>> FRAC_BITS);
		in_s6  <= in_s5;
		px_s6  <= px_s5;
		py_s6  <= py_s5;
		rad_s6 <= rad_s5;
		// s7: add center, saturate
		wx_s7  <= sat_coord(abs_x);
		wy_s7  <= sat_coord(abs_y);
		in_s7  <= in_s6;
		px_s7  <= px_s6;
		py_s7  <= py_s6;
		rad_s7 <= rad_s6;
	end

	always_comb begin
		recon.valid  = v_s7;
		recon.wx     = wx_s7;
		recon.wy     = wy_s7;
		recon.in_box = in_s7;
		recon.px     = px_s7;
		recon.py     = py_s7;
		recon.rad    = rad_s7;
	end

endmodule

`default_nettype wire

FILE: hdl/obbq_dist.sv
// obbq_dist: squared distance to the closest point against the squared radius
// depends on obbq_pkg; three register stages, the last drives the result
`timescale 1ns / 1ps
`default_nettype none

module obbq_dist import obbq_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire recon_t recon,
	output logic        done,
	output out_word_t   result
);

	logic                      v_s8, v_s9, v_s10;
	logic [COORD_W-1:0]        mx_s8, my_s8;
	logic                      big_s8, big_s9;
	logic [SQ_W-1:0]           sqx_s9, sqy_s9;
	logic [R2_W-1:0]           r2_s9;
	logic [EXT_W-1:0]          rad_s8;
	logic signed [COORD_W-1:0] wx_s8, wy_s8, wx_s9, wy_s9;
	logic                      in_s8, in_s9;
	out_word_t                 res_s10;

	logic signed [DIFF_W-1:0]  ex, ey;
	logic [DIFF_W-1:0]         ax, ay;
	logic [SQ_W:0]             d2;

	always_comb begin
		ex = DIFF_W'(recon.px) - DIFF_W'(recon.wx);
		ey = DIFF_W'(recon.py) - DIFF_W'(recon.wy);
		ax = ex[DIFF_W-1] ? DIFF_W'(-ex) : DIFF_W'(ex);
		ay = ey[DIFF_W-1] ? DIFF_W'(-ey) : DIFF_W'(ey);
		d2 = (SQ_W+1)'(sqx_s9) + (SQ_W+1)'(sqy_s9);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s8  <= recon.valid;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		// s8: component magnitudes; one past the word range never overlaps
		mx_s8  <= ax[COORD_W-1:0];
		my_s8  <= ay[COORD_W-1:0];
		big_s8 <= ax[COORD_W] || ay[COORD_W];
		rad_s8 <= recon.rad;
		wx_s8  <= recon.wx;
		wy_s8  <= recon.wy;
		in_s8  <= recon.in_box;
		// s9: squares
		sqx_s9 <= SQ_W'(mx_s8 * mx_s8);
		sqy_s9 <= SQ_W'(my_s8 * my_s8);
		r2_s9  <= R2_W'(rad_s8 * rad_s8);
		big_s9 <= big_s8;
		wx_s9  <= wx_s8;
		wy_s9  <= wy_s8;
		in_s9  <= in_s8;
		// s10: compare and present
		res_s10.closest_x     <= wx_s9;
		res_s10.closest_y     <= wy_s9;
		res_s10.inside_box    <= in_s9;
		res_s10.disc_overlaps <= !big_s9 && (d2 <= (SQ_W+1)'(r2_s9));
	end

	assign done   = v_s10;
	assign result = res_s10;

endmodule

`default_nettype wire

FILE: hdl/oriented_box_point_query.sv
// oriented_box_point_query: top level of the 2d oriented box closest point query
// depends on obbq_pkg, obbq_cfg, obbq_proj, obbq_recon, obbq_dist
`timescale 1ns / 1ps
`default_nettype none

// one query word is taken at every clock edge with start high; busy is never
// raised, so a new word may follow in every cycle. each word gives exactly one
// result word, shown on result with done high for a single cycle once it has
// passed the ten stage register pipeline (offset subtract, axis multiply,
// rescale, clamp, multiply back, rescale, add center, magnitude, square and
// compare each sit in their own stage). the result cannot be held off, so a
// receiver must take it in the cycle it appears. box registers are written
// through wr_en / wr_index / wr_data and must only change while no word is in
// flight; the pipeline reads them live. coordinates are signed q16.16, the axis
// signed q2.16, radius and extents unsigned q15.16; the closest point saturates
// to the 32-bit range

module oriented_box_point_query import obbq_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// query channel
	input  wire logic               start,
	output logic                    busy,
	input  wire in_word_t           query,
	// result channel
	output logic                    done,
	output out_word_t               result,
	// box setup
	input  wire logic               wr_en,
	input  wire logic [IDX_W-1:0]   wr_index,
	input  wire logic [COORD_W-1:0] wr_data
);

	cfg_t   cfg;
	proj_t  proj;
	recon_t recon;
	logic   accept;

	// fully pipelined, never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// box setup registers
	obbq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// world to local, clamp, containment flag
	obbq_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_word  (query),
		.cfg      (cfg),
		.proj     (proj)
	);

	// local back to world, saturating
	obbq_recon u_recon (
		.clk    (clk),
		.arst_n (arst_n),
		.proj   (proj),
		.cfg    (cfg),
		.recon  (recon)
	);

	// disc overlap and result register
	obbq_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.recon  (recon),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for oriented_box_point_query, with a driver, a monitor and an
// in-bench closest point predictor that runs directed and random query words across box setups
// depends on obbq_pkg and the oriented_box_point_query rtl
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import obbq_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PIPE_DRAIN   = 14;       // margin for the pipeline to drain
	localparam int SETUPS       = 8;
	localparam int WORDS_PER_SETUP = 175;
	localparam int PRINT_CAP    = 100;

	// register indexes past the end of the list: writes there must change nothing
	localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
	localparam logic [EXT_W-1:0]   RAD_MAX   = 31'h7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_word_t query = '0;
	logic done;
	out_word_t result;
	logic wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [COORD_W-1:0] wr_data = '0;

	oriented_box_point_query dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.query    (query),
		.done     (done),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// words waiting to be offered, and results predicted for words already taken
	in_word_t  point_feed[$];
	out_word_t closest_q[$];

	// shadow copy of the box registers, updated from the write port
	cfg_t box_regs;

	int unsigned send_idle_pct = 6;
	logic word_taken = 1'b0;
	int words_taken = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int inside_seen = 0;
	int overlap_seen = 0;
	int setup_count = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("%0t ns: mismatch on word %0d: %s", $realtime, results_seen, what);
	endtask

	// saturate a wide value to the signed coordinate range
	function automatic longint clip_coord(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (COORD_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// closest box point, containment and disc overlap for one query word
	function automatic out_word_t closest_point_of(input in_word_t q, input cfg_t b);
		longint px, py, cx, cy, rx, ry, hw, hh;
		longint dx, dy, lx, ly, kx, ky, wx, wy, ex, ey;
		logic [69:0] ax, ay, d2, r2;
		out_word_t r;
		px = q.point_x;
		py = q.point_y;
		cx = b.center_x;
		cy = b.center_y;
		rx = b.right_x;
		ry = b.right_y;
		hw = longint'(b.half_width);
		hh = longint'(b.half_height);
		dx = px - cx;
		dy = py - cy;
		// project onto right and up = (-ry, rx); >>> on longint floors toward minus infinity
		lx = (dx * rx + dy * ry) >>> FRAC_BITS;
		ly = (dy * rx - dx * ry) >>> FRAC_BITS;
		r.inside_box = (lx <= hw) && (lx >= -hw) && (ly <= hh) && (ly >= -hh);
		kx = (lx > hw) ? hw : ((lx < -hw) ? -hw : lx);
		ky = (ly > hh) ? hh : ((ly < -hh) ? -hh : ly);
		wx = clip_coord(cx + ((kx * rx - ky * ry) >>> FRAC_BITS));
		wy = clip_coord(cy + ((kx * ry + ky * rx) >>> FRAC_BITS));
		r.closest_x = COORD_W'(wx);
		r.closest_y = COORD_W'(wy);
		// exact squares in a wide vector; anything past 64 bits is beyond any radius anyway
		ex = px - wx;
		ey = py - wy;
		ax = 70'(ex < 0 ? -ex : ex);
		ay = 70'(ey < 0 ? -ey : ey);
		d2 = ax * ax + ay * ay;
		r2 = 70'(q.disc_radius) * 70'(q.disc_radius);
		r.disc_overlaps = (d2 <= r2);
		return r;
	endfunction

	// driver: a word stays on the port until taken, then the next one may follow
	always @(negedge clk) begin
		if (!start || word_taken) begin
			if (point_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				query <= point_feed.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor, predictor and watchdog, all on the rising edge
	always @(posedge clk) begin : check_results
		out_word_t want;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending", cycle_count,
				closest_q.size());
			$display("end of test: mismatches");
			$finish;
		end
		if (!arst_n) begin
			box_regs.center_x    = '0;
			box_regs.center_y    = '0;
			box_regs.right_x     = AXIS_ONE;
			box_regs.right_y     = '0;
			box_regs.half_width  = EXT_ONE;
			box_regs.half_height = EXT_ONE;
		end else if (wr_en) begin
			// upper bits beyond a register's width are dropped
			case (wr_index)
				REG_CENTER_X:    box_regs.center_x    = wr_data;
				REG_CENTER_Y:    box_regs.center_y    = wr_data;
				REG_RIGHT_X:     box_regs.right_x     = wr_data[AXIS_W-1:0];
				REG_RIGHT_Y:     box_regs.right_y     = wr_data[AXIS_W-1:0];
				REG_HALF_WIDTH:  box_regs.half_width  = wr_data[EXT_W-1:0];
				REG_HALF_HEIGHT: box_regs.half_height = wr_data[EXT_W-1:0];
				default: ;
			endcase
		end
		// result side first: a word taken at this edge cannot already be out
		if (done !== 1'b0) begin
			if (closest_q.size() == 0) begin
				flag_mismatch("result word with nothing outstanding");
			end else begin
				want = closest_q.pop_front();
				if (result.closest_x !== want.closest_x)
					flag_mismatch($sformatf("closest_x got %0d want %0d",
						result.closest_x, want.closest_x));
				if (result.closest_y !== want.closest_y)
					flag_mismatch($sformatf("closest_y got %0d want %0d",
						result.closest_y, want.closest_y));
				if (result.inside_box !== want.inside_box)
					flag_mismatch($sformatf("inside_box got %b want %b",
						result.inside_box, want.inside_box));
				if (result.disc_overlaps !== want.disc_overlaps)
					flag_mismatch($sformatf("disc_overlaps got %b want %b",
						result.disc_overlaps, want.disc_overlaps));
				if (want.inside_box)
					inside_seen <= inside_seen + 1;
				if (want.disc_overlaps)
					overlap_seen <= overlap_seen + 1;
				results_seen <= results_seen + 1;
			end
		end
		word_taken <= start && !busy;
		if (start && !busy) begin
			closest_q.push_back(closest_point_of(query, box_regs));
			words_taken <= words_taken + 1;
		end
	end

	// pipeline is empty once every word offered has been taken and answered
	task automatic wait_idle();
		do
			@(posedge clk);
		while (point_feed.size() != 0 || start || words_taken != results_seen);
	endtask

	task automatic write_box_reg(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	function automatic void queue_point(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [EXT_W-1:0] rad);
		in_word_t w;
		w.point_x = x;
		w.point_y = y;
		w.disc_radius = rad;
		point_feed.push_back(w);
	endfunction

	// mostly near the box, now and then anywhere in the coordinate range
	function automatic logic [COORD_W-1:0] pick_coord(input logic signed [COORD_W-1:0] around,
		input int unsigned span);
		longint off;
		if ($urandom_range(0, 7) == 0)
			return $urandom();
		off = longint'($urandom_range(0, 2 * span)) - longint'(span);
		return COORD_W'(longint'(around) + off);
	endfunction

	function automatic logic [EXT_W-1:0] pick_extent();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return EXT_W'($urandom());
			2: return EXT_W'($urandom_range(0, 32'h1000_0000));
			default: return EXT_W'($urandom_range(0, 32'h0040_0000));
		endcase
	endfunction

	// random box: center, axis (unit, rotated, or any 18-bit pair) and extents
	task automatic random_box_setup(output logic signed [COORD_W-1:0] cx,
		output logic signed [COORD_W-1:0] cy, output int unsigned span);
		int ax, ay;
		logic [EXT_W-1:0] hw, hh;
		longint reach;
		cx = ($urandom_range(0, 3) == 0) ? $urandom()
			: COORD_W'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
		cy = ($urandom_range(0, 3) == 0) ? $urandom()
			: COORD_W'(int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
		case ($urandom_range(0, 7))
			0: begin ax = 65536; ay = 0; end
			1: begin ax = 0; ay = -65536; end
			2: begin ax = 46341; ay = -46341; end
			3: begin ax = -56756; ay = 32768; end
			4: begin ax = int'($urandom_range(0, 131072)) - 65536;
				ay = int'($urandom_range(0, 131072)) - 65536; end
			5: begin ax = -65536; ay = 0; end
			default: begin ax = int'($urandom()); ay = int'($urandom()); end
		endcase
		hw = pick_extent();
		hh = pick_extent();
		write_box_reg(REG_CENTER_X, cx);
		write_box_reg(REG_CENTER_Y, cy);
		// junk above the axis and extent widths must be dropped
		write_box_reg(REG_RIGHT_X, ($urandom() & 32'hFFFC_0000) | (32'(ax) & 32'h0003_FFFF));
		write_box_reg(REG_RIGHT_Y, ($urandom() & 32'hFFFC_0000) | (32'(ay) & 32'h0003_FFFF));
		write_box_reg(REG_HALF_WIDTH, ($urandom() & 32'h8000_0000) | 32'(hw));
		write_box_reg(REG_HALF_HEIGHT, ($urandom() & 32'h8000_0000) | 32'(hh));
		reach = 2 * longint'((hw > hh) ? hw : hh) + 262144;
		span = (reach > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(reach);
	endtask

	initial begin : run
		logic signed [COORD_W-1:0] cx, cy;
		int unsigned span;
		logic [EXT_W-1:0] rad;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset box is the square of half width and half height one about the origin
		@(posedge clk);
		queue_point('0, '0, '0);
		queue_point(32'd65536, 32'd65536, '0);          // corner, boundary counts as inside
		queue_point(32'd65537, '0, '0);                 // one lsb outside
		queue_point(32'd131072, '0, 31'd65536);         // disc just touching
		queue_point(32'd131073, '0, 31'd65536);         // disc one lsb short
		queue_point(COORD_MAX, COORD_MAX, RAD_MAX);
		queue_point(COORD_MIN, COORD_MIN, '0);          // squared distance still within 64 bits
		wait_idle();

		// extreme box: center near the corner of largest x and smallest y, largest axis and extents;
		// the x axis value arrives with junk above bit 17, extents with bit 31 set
		write_box_reg(REG_CENTER_X, 32'h7FFF_0000);
		write_box_reg(REG_CENTER_Y, 32'h8001_0000);
		write_box_reg(REG_RIGHT_X, 32'hFFFD_FFFF);
		write_box_reg(REG_RIGHT_Y, 32'h0002_0000);
		write_box_reg(REG_HALF_WIDTH, 32'hFFFF_FFFF);
		write_box_reg(REG_HALF_HEIGHT, 32'hFFFF_FFFF);
		@(posedge clk);
		queue_point(COORD_MAX, COORD_MIN, '0);          // closest point saturates
		queue_point('0, '0, RAD_MAX);
		queue_point(COORD_MIN, COORD_MAX, 31'd12345);
		queue_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd1);
		wait_idle();

		// zero sized box on a 45 degree axis; negative products exercise floor rounding
		write_box_reg(REG_CENTER_X, 32'hEDCB_A988);
		write_box_reg(REG_CENTER_Y, 32'h0ABC_DEF0);
		write_box_reg(REG_RIGHT_X, 32'd46341);
		write_box_reg(REG_RIGHT_Y, 32'd46341);
		write_box_reg(REG_HALF_WIDTH, '0);
		write_box_reg(REG_HALF_HEIGHT, '0);
		// spare indexes must leave the box alone
		write_box_reg(IDX_SPARE_LO, 32'hDEAD_BEEF);
		write_box_reg(IDX_SPARE_HI, 32'h1234_5678);
		@(posedge clk);
		queue_point(32'hEDCB_A988, 32'h0ABC_DEF0, '0);  // exactly at the center
		queue_point(32'hEDCB_A987, 32'h0ABC_DEEF, '0);
		queue_point(-32'sd3, -32'sd7, 31'd5);
		queue_point(32'hEDCB_A989, 32'h0ABC_DEF1, 31'd2);
		wait_idle();

		// axis pointing left, uneven extents of 3.5 by 0.25
		write_box_reg(REG_CENTER_X, '0);
		write_box_reg(REG_CENTER_Y, '0);
		write_box_reg(REG_RIGHT_X, 32'hFFFF_0000);
		write_box_reg(REG_RIGHT_Y, '0);
		write_box_reg(REG_HALF_WIDTH, 32'd229376);
		write_box_reg(REG_HALF_HEIGHT, 32'd16384);
		@(posedge clk);
		queue_point(-32'sd229376, 32'd16384, '0);       // on the far corner
		queue_point(32'd229377, '0, 31'd1);
		queue_point('0, -32'sd16385, 31'd1);
		queue_point(-32'sd5, 32'd3, '0);

		// random part: fast sender, then a sparse one, then back to back
		for (int s = 0; s < SETUPS; s++) begin
			wait_idle();
			send_idle_pct = (s < 3) ? 6 : ((s < 6) ? 88 : 0);
			random_box_setup(cx, cy, span);
			if ($urandom_range(0, 2) == 0)
				write_box_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom());
			setup_count++;
			@(posedge clk);
			for (int n = 0; n < WORDS_PER_SETUP; n++) begin
				case ($urandom_range(0, 3))
					0: rad = '0;
					1: rad = EXT_W'($urandom());
					default: rad = EXT_W'($urandom_range(0, span));
				endcase
				queue_point(pick_coord(cx, span), pick_coord(cy, span), rad);
			end
		end

		wait_idle();
		repeat (PIPE_DRAIN) @(posedge clk);
		@(negedge clk);
		if (closest_q.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", closest_q.size()));
		$display("checked %0d query words over %0d random box setups plus directed boxes",
			results_seen, setup_count);
		$display("%0d points inside, %0d discs overlapping, %0d mismatches",
			inside_seen, overlap_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire
